@@ hdl/vpmb_pkg.sv @@
// vpmb_pkg: shared types and constants for the view-projection matrix builder.
// Pose and row payload structs, register indexes. No dependencies.
package vpmb_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR     = 3'd6;

	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] angle_x_deg;
		logic signed [31:0] angle_y_deg;
		logic signed [31:0] angle_z_deg;
	} pose_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] col0_value;
		logic signed [31:0] col1_value;
		logic signed [31:0] col2_value;
		logic signed [31:0] col3_value;
		logic               last_row;
	} row_t;

endpackage

@@ hdl/view_projection_matrix_builder.sv @@
// Top level of the view-projection matrix builder: pose pipeline, projection divider,
// row serializer. Depends on vpmb_pkg.
//
// Each accepted pose beat yields four row beats (row 0 first, last_row on row 3) of the
// Q16.16 matrix P*T*S*Rz*Ry*Rx. A pose passes through eight pipeline stages (angle
// reduction, table index, sine table, two rotation products, scale, projection multiply,
// rounding) and then a row serializer that registers the matrix; sustained throughput
// is limited by the single row output port, which carries the four rows of each pose
// one beat at a time. The projection terms come from a bit-serial restoring divider:
// after reset and after every write to registers 0..6 it runs one setup step, then a
// load, a divide and a store for each of the four terms; pose_stall stays high meanwhile.
// Register writes are always taken (cfg_ready is tied high); index 7 is ignored.
module view_projection_matrix_builder #(
	parameter int TRIG_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pose_valid,
	output logic                            pose_stall,
	input  vpmb_pkg::pose_t                 pose,
	output logic                            row_valid,
	input  logic                            row_stall,
	output vpmb_pkg::row_t                  row,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vpmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int TB    = TRIG_TABLE_BITS;
	localparam int SHR   = 19 - TB;
	localparam int VW    = 32 - SHR;
	localparam int UW    = TB + 14;
	localparam int RSH   = UW + 6;
	localparam int PW    = 2 * UW + 1;
	localparam int IW    = TB - 1;
	localparam int QTR   = 1 << (TB - 2);
	localparam int TBL_N = QTR + 1;
	localparam longint unsigned RCP = ((64'd1 << RSH) + 64'd44) / 64'd45;
	localparam longint unsigned OFF = 64'd45 << (TB + 7);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int NUM_W = 63;
	localparam int CNT_W = 6;
	localparam logic [1:0] PT_P0 = 2'd0;
	localparam logic [1:0] PT_P1 = 2'd1;
	localparam logic [1:0] PT_P2 = 2'd2;
	localparam logic [1:0] PT_P3 = 2'd3;

	localparam logic signed [65:0] MAX66 = 66'sd2147483647;
	localparam logic signed [65:0] MIN66 = -66'sd2147483648;

	typedef enum logic [2:0] {PJ_IDLE, PJ_PREP, PJ_LOAD, PJ_DIV, PJ_STORE} pj_state_t;

	// quarter-wave sine entry, elaboration only
	function automatic logic [16:0] qsin(input int unsigned m);
		longint unsigned x, x2, term;
		longint acc;
		x = (64'(m) * HALF_PI_Q30) >> (TB - 2);
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		acc = acc - longint'(term);
		if (acc < 0) acc = 0;
		acc = (acc + 64'sd8192) >>> 14;
		if (acc > 65536) acc = 65536;
		return 17'(acc);
	endfunction

	// round half up from Q32.32 to Q16.16, saturate
	function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v);
		logic signed [65:0] t;
		t = (v + 66'sd32768) >>> 16;
		if (t > MAX66) return 32'sh7fffffff;
		if (t < MIN66) return 32'sh80000000;
		return 32'(t);
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		if (v == 32'sh80000000) return 32'sh7fffffff;
		return -v;
	endfunction

	// ---------------- configuration and projection terms ----------------
	logic signed [31:0] scale_q [3];
	logic [30:0]        fr_q [4];
	logic               cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_hit = cfg_valid && cfg_ready && (cfg_index <= vpmb_pkg::CFG_FAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q[0] <= 32'sd65536;
			scale_q[1] <= 32'sd65536;
			scale_q[2] <= 32'sd65536;
			fr_q[0] <= 31'd6554;
			fr_q[1] <= 31'd6554;
			fr_q[2] <= 31'd6554;
			fr_q[3] <= 31'd655360;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vpmb_pkg::CFG_SCALE_X: scale_q[0] <= cfg_data;
				vpmb_pkg::CFG_SCALE_Y: scale_q[1] <= cfg_data;
				vpmb_pkg::CFG_SCALE_Z: scale_q[2] <= cfg_data;
				vpmb_pkg::CFG_RIGHT:   fr_q[0] <= cfg_data[30:0];
				vpmb_pkg::CFG_TOP:     fr_q[1] <= cfg_data[30:0];
				vpmb_pkg::CFG_NEAR:    fr_q[2] <= cfg_data[30:0];
				vpmb_pkg::CFG_FAR:     fr_q[3] <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic [61:0] fn_prod_q;
	always_ff @(posedge clk) begin
		fn_prod_q <= 62'(fr_q[3]) * 62'(fr_q[2]);
	end

	pj_state_t          pj_state_q;
	logic [1:0]         pj_sel_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   quo_q;
	logic [30:0]        rem_q;
	logic [30:0]        den_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [31:0] pterm_q [4];

	logic               fn_ge;
	logic [30:0]        fn_diff;
	logic [31:0]        fn_sum;
	logic [NUM_W-1:0]   pj_num;
	logic [30:0]        pj_den;
	logic               pj_neg;
	logic [31:0]        rem_sh;
	logic               qbit;
	logic [30:0]        rem_nx;
	logic [NUM_W-1:0]   pj_lim;
	logic [NUM_W-1:0]   pj_qc;
	logic signed [31:0] pj_res;
	logic               busy;

	always_comb begin
		fn_ge = fr_q[3] >= fr_q[2];
		fn_diff = fn_ge ? fr_q[3] - fr_q[2] : fr_q[2] - fr_q[3];
		fn_sum = 32'(fr_q[3]) + 32'(fr_q[2]);
		case (pj_sel_q)
			PT_P0: begin
				pj_num = {16'd0, fr_q[2], 16'd0};
				pj_den = fr_q[0];
				pj_neg = 1'b0;
			end
			PT_P1: begin
				pj_num = {16'd0, fr_q[2], 16'd0};
				pj_den = fr_q[1];
				pj_neg = 1'b0;
			end
			PT_P2: begin
				pj_num = {15'd0, fn_sum, 16'd0};
				pj_den = fn_diff;
				pj_neg = fn_ge;
			end
			default: begin
				pj_num = {fn_prod_q, 1'b0};
				pj_den = fn_diff;
				pj_neg = fn_ge;
			end
		endcase
		rem_sh = {rem_q, num_q[NUM_W-1]};
		qbit = rem_sh >= {1'b0, den_q};
		rem_nx = qbit ? 31'(rem_sh - {1'b0, den_q}) : rem_sh[30:0];
		pj_lim = neg_q ? NUM_W'(64'h80000000) : NUM_W'(64'h7fffffff);
		pj_qc = (den_q == '0 || quo_q > pj_lim) ? pj_lim : quo_q;
		pj_res = neg_q ? 32'(-pj_qc) : 32'(pj_qc);
		busy = pj_state_q != PJ_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pj_state_q <= PJ_PREP;
			pj_sel_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < 4; i++) pterm_q[i] <= '0;
		end else if (cfg_hit) begin
			pj_state_q <= PJ_PREP;
		end else begin
			case (pj_state_q)
				PJ_IDLE: ;
				PJ_PREP: begin
					pj_sel_q <= PT_P0;
					pj_state_q <= PJ_LOAD;
				end
				PJ_LOAD: begin
					num_q <= pj_num;
					den_q <= pj_den;
					neg_q <= pj_neg;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CNT_W'(NUM_W - 1);
					pj_state_q <= PJ_DIV;
				end
				PJ_DIV: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[NUM_W-2:0], qbit};
					num_q <= num_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) pj_state_q <= PJ_STORE;
				end
				PJ_STORE: begin
					pterm_q[pj_sel_q] <= pj_res;
					if (pj_sel_q == PT_P3) begin
						pj_state_q <= PJ_IDLE;
					end else begin
						pj_sel_q <= pj_sel_q + 1'b1;
						pj_state_q <= PJ_LOAD;
					end
				end
				default: pj_state_q <= PJ_IDLE;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic [8:1] vld_q;
	logic [9:1] rdy;
	logic       ser_v_q;
	logic [1:0] row_q;
	logic       pose_go;

	assign pose_go = pose_valid && !busy;
	assign pose_stall = busy || !rdy[1];

	always_comb begin
		rdy[9] = !ser_v_q || (!row_stall && (row_q == vpmb_pkg::ROW_LAST));
		for (int k = 8; k >= 1; k--) rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= pose_go;
			for (int k = 2; k <= 8; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ---------------- s1: angle reduction multiply ----------------
	logic signed [31:0]   ang_in [3];
	logic signed [VW-1:0] ang_sh [3];
	logic [UW-1:0]        ang_u [3];
	logic [PW-1:0]        ang_p [3];
	logic signed [31:0]   pos_s1 [3];
	logic [PW-1:0]        angp_s1 [3];

	assign ang_in[0] = pose.angle_x_deg;
	assign ang_in[1] = pose.angle_y_deg;
	assign ang_in[2] = pose.angle_z_deg;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ang_sh[a] = VW'(ang_in[a] >>> SHR);
			ang_u[a] = UW'(ang_sh[a]) + UW'(OFF);
			ang_p[a] = PW'(ang_u[a]) * PW'(RCP);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			pos_s1[0] <= pose.pos_x;
			pos_s1[1] <= pose.pos_y;
			pos_s1[2] <= pose.pos_z;
			angp_s1 <= ang_p;
		end
	end

	// ---------------- s2: table index and quadrant ----------------
	logic [TB-1:0]      ang_k [3];
	logic [1:0]         c_quad [3];
	logic [IW-1:0]      s_idx [3];
	logic [IW-1:0]      c_idx [3];
	logic signed [31:0] pos_s2 [3];
	logic [IW-1:0]      sidx_s2 [3];
	logic [IW-1:0]      cidx_s2 [3];
	logic [2:0]         sneg_s2;
	logic [2:0]         cneg_s2;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ang_k[a] = angp_s1[a][RSH +: TB];
			c_quad[a] = ang_k[a][TB-1 -: 2] + 2'd1;
			s_idx[a] = ang_k[a][TB-2] ? IW'(QTR) - {1'b0, ang_k[a][TB-3:0]}
				: {1'b0, ang_k[a][TB-3:0]};
			c_idx[a] = c_quad[a][0] ? IW'(QTR) - {1'b0, ang_k[a][TB-3:0]}
				: {1'b0, ang_k[a][TB-3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			pos_s2 <= pos_s1;
			sidx_s2 <= s_idx;
			cidx_s2 <= c_idx;
			for (int a = 0; a < 3; a++) begin
				sneg_s2[a] <= ang_k[a][TB-1];
				cneg_s2[a] <= c_quad[a][1];
			end
		end
	end

	// ---------------- s3: sine table ----------------
	logic [16:0] sin_rom [TBL_N];
	for (genvar g = 0; g < TBL_N; g++) begin : g_rom
		assign sin_rom[g] = qsin(g);
	end

	logic signed [31:0] pos_s3 [3];
	logic signed [17:0] sn_s3 [3];
	logic signed [17:0] cs_s3 [3];

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			pos_s3 <= pos_s2;
			for (int a = 0; a < 3; a++) begin
				sn_s3[a] <= sneg_s2[a] ? -$signed({1'b0, sin_rom[sidx_s2[a]]})
					: $signed({1'b0, sin_rom[sidx_s2[a]]});
				cs_s3[a] <= cneg_s2[a] ? -$signed({1'b0, sin_rom[cidx_s2[a]]})
					: $signed({1'b0, sin_rom[cidx_s2[a]]});
			end
		end
	end

	// ---------------- s4: Ry*Rx and Rz*Ry terms ----------------
	logic signed [31:0] pos_s4 [3];
	logic signed [17:0] sn_s4 [3];
	logic signed [17:0] cs_s4 [3];
	logic signed [17:0] a01_s4, a02_s4, a21_s4, a22_s4, b00_s4, b10_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			pos_s4 <= pos_s3;
			sn_s4 <= sn_s3;
			cs_s4 <= cs_s3;
			a01_s4 <= 18'(rnd_sat(66'(sn_s3[1]) * 66'(sn_s3[0])));
			a02_s4 <= 18'(rnd_sat(66'(sn_s3[1]) * 66'(cs_s3[0])));
			a21_s4 <= 18'(rnd_sat(66'(cs_s3[1]) * 66'(sn_s3[0])));
			a22_s4 <= 18'(rnd_sat(66'(cs_s3[1]) * 66'(cs_s3[0])));
			b00_s4 <= 18'(rnd_sat(66'(cs_s3[2]) * 66'(cs_s3[1])));
			b10_s4 <= 18'(rnd_sat(66'(sn_s3[2]) * 66'(cs_s3[1])));
		end
	end

	// ---------------- s5: Rz*(Ry*Rx) ----------------
	logic signed [31:0] pos_s5 [3];
	logic signed [19:0] bm_s5 [3][3];

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			pos_s5 <= pos_s4;
			bm_s5[0][0] <= 20'(b00_s4);
			bm_s5[0][1] <= 20'(rnd_sat(66'(cs_s4[2]) * 66'(a01_s4)
				- 66'(sn_s4[2]) * 66'(cs_s4[0])));
			bm_s5[0][2] <= 20'(rnd_sat(66'(cs_s4[2]) * 66'(a02_s4)
				+ 66'(sn_s4[2]) * 66'(sn_s4[0])));
			bm_s5[1][0] <= 20'(b10_s4);
			bm_s5[1][1] <= 20'(rnd_sat(66'(sn_s4[2]) * 66'(a01_s4)
				+ 66'(cs_s4[2]) * 66'(cs_s4[0])));
			bm_s5[1][2] <= 20'(rnd_sat(66'(sn_s4[2]) * 66'(a02_s4)
				- 66'(cs_s4[2]) * 66'(sn_s4[0])));
			bm_s5[2][0] <= -20'(sn_s4[1]);
			bm_s5[2][1] <= 20'(a21_s4);
			bm_s5[2][2] <= 20'(a22_s4);
		end
	end

	// ---------------- s6: scale ----------------
	logic signed [31:0] pos_s6 [3];
	logic signed [31:0] cm_s6 [3][3];

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			pos_s6 <= pos_s5;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cm_s6[i][j] <= rnd_sat(66'(scale_q[i]) * 66'(bm_s5[i][j]));
				end
			end
		end
	end

	// ---------------- s7: projection products ----------------
	logic signed [63:0] prod_s7 [3][4];
	logic signed [31:0] r3_s7 [4];

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			for (int j = 0; j < 3; j++) begin
				prod_s7[0][j] <= 64'(pterm_q[0]) * 64'(cm_s6[0][j]);
				prod_s7[1][j] <= 64'(pterm_q[1]) * 64'(cm_s6[1][j]);
				prod_s7[2][j] <= 64'(pterm_q[2]) * 64'(cm_s6[2][j]);
				r3_s7[j] <= neg_sat(cm_s6[2][j]);
			end
			prod_s7[0][3] <= 64'(pterm_q[0]) * 64'(pos_s6[0]);
			prod_s7[1][3] <= 64'(pterm_q[1]) * 64'(pos_s6[1]);
			prod_s7[2][3] <= 64'(pterm_q[2]) * 64'(pos_s6[2]);
			r3_s7[3] <= neg_sat(pos_s6[2]);
		end
	end

	// ---------------- s8: round and saturate ----------------
	logic signed [31:0] mat_s8 [4][4];

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mat_s8[i][j] <= rnd_sat(66'(prod_s7[i][j]));
				end
			end
			mat_s8[0][3] <= rnd_sat(66'(prod_s7[0][3]));
			mat_s8[1][3] <= rnd_sat(66'(prod_s7[1][3]));
			mat_s8[2][3] <= rnd_sat(66'(prod_s7[2][3]) + (66'(pterm_q[3]) <<< 16));
			mat_s8[3] <= r3_s7;
		end
	end

	// ---------------- row serializer ----------------
	logic signed [31:0] ser_q [4][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			row_q <= '0;
		end else if (rdy[9]) begin
			ser_v_q <= vld_q[8];
			row_q <= '0;
		end else if (!row_stall) begin
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[9]) ser_q <= mat_s8;
	end

	assign row_valid = ser_v_q;

	always_comb begin
		row.row_index = row_q;
		row.col0_value = ser_q[row_q][0];
		row.col1_value = ser_q[row_q][1];
		row.col2_value = ser_q[row_q][2];
		row.col3_value = ser_q[row_q][3];
		row.last_row = row_q == vpmb_pkg::ROW_LAST;
	end

endmodule

@@ hdl/vpmb_checker.sv @@
// vpmb_assertions: port-level assertions for view_projection_matrix_builder, bound below.
// Depends on vpmb_pkg.
module vpmb_assertions (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pose_stall,
	input logic                           row_valid,
	input logic                           row_stall,
	input vpmb_pkg::row_t                 row,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [vpmb_pkg::CFG_IDX_W-1:0] cfg_index
);

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_stall |=> row_valid && $stable(row))
		else $error("row beat changed while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (row.last_row == (row.row_index == vpmb_pkg::ROW_LAST)))
		else $error("last_row does not match row_index");

	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall && !row.last_row
		|=> row_valid && (row.row_index == $past(row.row_index) + 2'd1))
		else $error("rows of a matrix not back to back in order");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index <= vpmb_pkg::CFG_FAR) |=> pose_stall)
		else $error("pose taken while projection terms recompute");

endmodule

bind view_projection_matrix_builder vpmb_assertions u_vpmb_assertions (
	.clk(clk),
	.arst_n(arst_n),
	.pose_stall(pose_stall),
	.row_valid(row_valid),
	.row_stall(row_stall),
	.row(row),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index)
);
